### rtl/sa_pkg.sv
// Shared types and constants for the slot allocator: field widths, mode and
// status codes, and the control groups that drive the ring and slot tables.
// No dependencies.
package sa_pkg;

	localparam int DEF_CAPACITY     = 32;
	localparam int DEF_PAYLOAD_BITS = 64;

	localparam int MODE_W   = 2;
	localparam int SLOT_W   = 6;
	localparam int GEN_W    = 32;
	localparam int CNT_W    = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_ACQUIRE = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_LIST    = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EVICT  = 2'd1,
		ST_REJECT = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef enum logic {
		PTR_INC = 1'b0,
		PTR_DEC = 1'b1
	} ptr_op_t;

	// Order ring port: one registered read and one write per cycle
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [SLOT_W-1:0] wr_data;
	} ring_ctl_t;

	// Slot tables: one read address, one write address for generation,
	// payload and live flag, and a separate write port for ring positions
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic [SLOT_W-1:0] wr_addr;
		logic              gen_we;
		logic [GEN_W-1:0]  gen_wdata;
		logic              pay_we;
		logic              live_we;
		logic              live_wval;
		logic              pos_we;
		logic [SLOT_W-1:0] pos_waddr;
		logic [SLOT_W-1:0] pos_wdata;
	} slot_ctl_t;

	typedef struct packed {
		logic [GEN_W-1:0]  gen;
		logic              live;
		logic [SLOT_W-1:0] pos;
	} slot_rd_t;

endpackage

### rtl/sa_ptr_unit.sv
// Shared ring pointer unit: step a ring position forwards or backwards
// modulo the pool capacity. Uses sa_pkg.
module sa_ptr_unit #(
	parameter int CAPACITY = sa_pkg::DEF_CAPACITY,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  sa_pkg::ptr_op_t   op,
	input  logic [IDX_W-1:0]  a,
	output logic [IDX_W-1:0]  y
);

	localparam logic [IDX_W-1:0] TOP_POS = IDX_W'(CAPACITY - 1);

	always_comb begin
		unique case (op)
			sa_pkg::PTR_INC: y = (a == TOP_POS) ? '0 : a + 1'b1;
			sa_pkg::PTR_DEC: y = (a == '0) ? TOP_POS : a - 1'b1;
		endcase
	end

endmodule

### rtl/sa_ring.sv
// Order ring memory: slot numbers in age order, registered read. Entries
// never written read back as their own index. Uses sa_pkg.
module sa_ring #(
	parameter int CAPACITY = sa_pkg::DEF_CAPACITY,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sa_pkg::ring_ctl_t         ctl,
	output logic [sa_pkg::SLOT_W-1:0] rd_data
);

	logic [IDX_W-1:0]    mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [IDX_W-1:0]    rd_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic                rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.wr_en) begin
			vld_q[ctl.wr_addr[IDX_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr[IDX_W-1:0]] <= ctl.wr_data[IDX_W-1:0];
		end
		if (ctl.rd_en) begin
			rd_q      <= mem[ctl.rd_addr[IDX_W-1:0]];
			rd_vld_q  <= vld_q[ctl.rd_addr[IDX_W-1:0]];
			rd_addr_q <= ctl.rd_addr[IDX_W-1:0];
		end
	end

	// an untouched position still holds its reset slot number
	assign rd_data = sa_pkg::SLOT_W'(rd_vld_q ? rd_q : rd_addr_q);

endmodule

### rtl/sa_slots.sv
// Per-slot tables: generation counters, payload words, ring positions and
// live flags, all read together through one registered read. Uses sa_pkg.
module sa_slots #(
	parameter int CAPACITY     = sa_pkg::DEF_CAPACITY,
	parameter int PAYLOAD_BITS = sa_pkg::DEF_PAYLOAD_BITS,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sa_pkg::slot_ctl_t       ctl,
	input  logic [PAYLOAD_BITS-1:0] pay_wdata,
	output sa_pkg::slot_rd_t        rd,
	output logic [PAYLOAD_BITS-1:0] pay_rdata
);

	logic [sa_pkg::GEN_W-1:0] gen_mem [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  pay_mem [CAPACITY];
	logic [IDX_W-1:0]         pos_mem [CAPACITY];

	logic [CAPACITY-1:0] gen_vld_q;
	logic [CAPACITY-1:0] pay_vld_q;
	logic [CAPACITY-1:0] live_q;

	logic [sa_pkg::GEN_W-1:0] gen_rd_q;
	logic [PAYLOAD_BITS-1:0]  pay_rd_q;
	logic [IDX_W-1:0]         pos_rd_q;
	logic                     gen_vld_rd_q;
	logic                     pay_vld_rd_q;
	logic                     live_rd_q;

	logic [IDX_W-1:0] rd_a;
	logic [IDX_W-1:0] wr_a;

	assign rd_a = ctl.rd_addr[IDX_W-1:0];
	assign wr_a = ctl.wr_addr[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_vld_q <= '0;
			pay_vld_q <= '0;
			live_q    <= '0;
		end else begin
			if (ctl.gen_we) begin
				gen_vld_q[wr_a] <= 1'b1;
			end
			if (ctl.pay_we) begin
				pay_vld_q[wr_a] <= 1'b1;
			end
			if (ctl.live_we) begin
				live_q[wr_a] <= ctl.live_wval;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gen_we) begin
			gen_mem[wr_a] <= ctl.gen_wdata;
		end
		if (ctl.pay_we) begin
			pay_mem[wr_a] <= pay_wdata;
		end
		if (ctl.pos_we) begin
			pos_mem[ctl.pos_waddr[IDX_W-1:0]] <= ctl.pos_wdata[IDX_W-1:0];
		end
		if (ctl.rd_en) begin
			gen_rd_q     <= gen_mem[rd_a];
			pay_rd_q     <= pay_mem[rd_a];
			pos_rd_q     <= pos_mem[rd_a];
			gen_vld_rd_q <= gen_vld_q[rd_a];
			pay_vld_rd_q <= pay_vld_q[rd_a];
			live_rd_q    <= live_q[rd_a];
		end
	end

	// a slot never acquired reads as generation zero with an empty payload
	assign rd.gen    = gen_vld_rd_q ? gen_rd_q : '0;
	assign rd.live   = live_rd_q;
	assign rd.pos    = sa_pkg::SLOT_W'(pos_rd_q);
	assign pay_rdata = pay_vld_rd_q ? pay_rd_q : '0;

endmodule

### rtl/slot_allocator_fifo_eviction.sv
// Top level of the slot allocator: command sequencer, pointers and the
// result register. Uses sa_pkg, sa_ptr_unit, sa_ring and sa_slots.
//
// A pool of CAPACITY slots, handed out oldest-first: acquire takes the next
// free slot (evicting the oldest live one when the pool is full), release
// frees a live slot, query reports one slot and list walks the live slots
// oldest first with last set on the final beat. The block takes one command
// at a time and holds req_stall high until its final result is in the
// output register; a new command is taken while that result still waits.
// Each table access is a registered read: an acquire reads the ring, then the
// slot tables, then emits; a release reads both, checks the slot, then emits
// or rejects; a query, an out-of-range request or an empty list emits next;
// a list reads the ring and slots per live slot. rsp_stall holds any beat.
// No clearing pass is needed after reset.
module slot_allocator_fifo_eviction #(
	parameter int CAPACITY     = sa_pkg::DEF_CAPACITY,
	parameter int PAYLOAD_BITS = sa_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [sa_pkg::MODE_W-1:0]   mode,
	input  logic [sa_pkg::SLOT_W-1:0]   slot_index,
	input  logic [PAYLOAD_BITS-1:0]     payload,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [sa_pkg::STATUS_W-1:0] status,
	output logic [sa_pkg::SLOT_W-1:0]   result_slot,
	output logic [sa_pkg::SLOT_W-1:0]   evicted_slot,
	output logic [sa_pkg::GEN_W-1:0]    slot_generation,
	output logic                        slot_live,
	output logic [PAYLOAD_BITS-1:0]     slot_payload,
	output logic [sa_pkg::CNT_W-1:0]    live_count,
	output logic                        last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW    = sa_pkg::SLOT_W;
	localparam int CW    = sa_pkg::CNT_W;
	localparam int GW    = sa_pkg::GEN_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACQ_SLOT,
		S_ACQ_EMIT,
		S_REL_CHK,
		S_REL_EMIT,
		S_QRY_EMIT,
		S_LST_SLOT,
		S_LST_EMIT,
		S_REJECT,
		S_EMPTY
	} state_t;

	state_t                 state_q;
	logic [SW-1:0]          idx_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [IDX_W-1:0]       next_q;
	logic [IDX_W-1:0]       oldest_q;
	logic [IDX_W-1:0]       lastpos_q;
	logic [IDX_W-1:0]       walk_q;
	logic [IDX_W-1:0]       slot_q;
	logic [CW-1:0]          total_q;
	logic [CW-1:0]          remain_q;
	logic [GW-1:0]          gen_q;

	logic                    rsp_valid_q;
	sa_pkg::status_t         status_q;
	logic [SW-1:0]           result_slot_q;
	logic [SW-1:0]           evicted_slot_q;
	logic [GW-1:0]           gen_out_q;
	logic                    live_out_q;
	logic [PAYLOAD_BITS-1:0] pay_out_q;
	logic [CW-1:0]           count_out_q;
	logic                    last_q;

	sa_pkg::mode_t          req_mode;
	logic                   idx_ok;
	logic                   full;
	logic                   out_free;
	logic [IDX_W-1:0]       ring_slot;
	logic [GW-1:0]          gen_next;

	sa_pkg::ptr_op_t        ptr_op;
	logic [IDX_W-1:0]       ptr_a;
	logic [IDX_W-1:0]       ptr_y;

	sa_pkg::ring_ctl_t      ring_ctl;
	logic [SW-1:0]          ring_rd;
	sa_pkg::slot_ctl_t      slot_ctl;
	sa_pkg::slot_rd_t       slot_rd;
	logic [PAYLOAD_BITS-1:0] slot_pay;

	logic                    do_emit;
	sa_pkg::status_t         e_status;
	logic [SW-1:0]           e_slot;
	logic [SW-1:0]           e_evict;
	logic [GW-1:0]           e_gen;
	logic                    e_live;
	logic [PAYLOAD_BITS-1:0] e_pay;
	logic [CW-1:0]           e_count;
	logic                    e_last;

	assign req_stall = (state_q != S_IDLE);
	assign req_mode  = sa_pkg::mode_t'(mode);
	assign idx_ok    = (CW'(slot_index) < CAP_C);
	assign full      = (total_q == CAP_C);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign ring_slot = ring_rd[IDX_W-1:0];
	// a full acquire evicts and retakes the same slot: two generation bumps
	assign gen_next  = slot_rd.gen + (full ? GW'(2) : GW'(1));

	sa_ptr_unit #(.CAPACITY(CAPACITY)) u_ptr (
		.op (ptr_op),
		.a  (ptr_a),
		.y  (ptr_y)
	);

	sa_ring #(.CAPACITY(CAPACITY)) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.rd_data (ring_rd)
	);

	sa_slots #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (slot_ctl),
		.pay_wdata (pay_q),
		.rd        (slot_rd),
		.pay_rdata (slot_pay)
	);

	// pointer unit operand select
	always_comb begin
		ptr_op = sa_pkg::PTR_INC;
		ptr_a  = next_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_mode == sa_pkg::MODE_RELEASE) begin
					ptr_op = sa_pkg::PTR_DEC;
				end else if (req_mode == sa_pkg::MODE_LIST) begin
					ptr_a = oldest_q;
				end
			end
			S_LST_EMIT: ptr_a = walk_q;
			default: ;
		endcase
	end

	// table reads and writes
	always_comb begin
		ring_ctl = '0;
		slot_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (req_mode)
						sa_pkg::MODE_ACQUIRE: begin
							ring_ctl.rd_en   = 1'b1;
							ring_ctl.rd_addr = SW'(next_q);
						end
						sa_pkg::MODE_RELEASE: begin
							if (idx_ok) begin
								ring_ctl.rd_en   = 1'b1;
								ring_ctl.rd_addr = SW'(ptr_y);
								slot_ctl.rd_en   = 1'b1;
								slot_ctl.rd_addr = slot_index;
							end
						end
						sa_pkg::MODE_QUERY: begin
							if (idx_ok) begin
								slot_ctl.rd_en   = 1'b1;
								slot_ctl.rd_addr = slot_index;
							end
						end
						sa_pkg::MODE_LIST: begin
							if (total_q != '0) begin
								ring_ctl.rd_en   = 1'b1;
								ring_ctl.rd_addr = SW'(oldest_q);
							end
						end
					endcase
				end
			end
			S_ACQ_SLOT, S_LST_SLOT: begin
				slot_ctl.rd_en   = 1'b1;
				slot_ctl.rd_addr = SW'(ring_slot);
			end
			S_ACQ_EMIT: begin
				if (out_free) begin
					slot_ctl.wr_addr   = SW'(slot_q);
					slot_ctl.gen_we    = 1'b1;
					slot_ctl.gen_wdata = gen_next;
					slot_ctl.pay_we    = 1'b1;
					slot_ctl.live_we   = 1'b1;
					slot_ctl.live_wval = 1'b1;
					slot_ctl.pos_we    = 1'b1;
					slot_ctl.pos_waddr = SW'(slot_q);
					slot_ctl.pos_wdata = SW'(next_q);
				end
			end
			S_REL_CHK: begin
				if (slot_rd.live) begin
					slot_ctl.wr_addr   = idx_q;
					slot_ctl.live_we   = 1'b1;
					slot_ctl.live_wval = 1'b0;
					// move the newest slot into the freed position
					if (slot_rd.pos[IDX_W-1:0] != lastpos_q) begin
						ring_ctl.wr_en     = 1'b1;
						ring_ctl.wr_addr   = slot_rd.pos;
						ring_ctl.wr_data   = ring_rd;
						slot_ctl.pos_we    = 1'b1;
						slot_ctl.pos_waddr = ring_rd;
						slot_ctl.pos_wdata = slot_rd.pos;
					end
				end
			end
			S_REL_EMIT: begin
				if (out_free) begin
					ring_ctl.wr_en   = 1'b1;
					ring_ctl.wr_addr = SW'(lastpos_q);
					ring_ctl.wr_data = idx_q;
				end
			end
			S_LST_EMIT: begin
				if (out_free && remain_q != CW'(1)) begin
					ring_ctl.rd_en   = 1'b1;
					ring_ctl.rd_addr = SW'(walk_q);
				end
			end
			default: ;
		endcase
	end

	// result beat contents
	always_comb begin
		do_emit  = 1'b0;
		e_status = sa_pkg::ST_OK;
		e_slot   = idx_q;
		e_evict  = '0;
		e_gen    = '0;
		e_live   = 1'b0;
		e_pay    = '0;
		e_count  = total_q;
		e_last   = 1'b1;
		unique case (state_q)
			S_ACQ_EMIT: begin
				do_emit  = out_free;
				e_status = full ? sa_pkg::ST_EVICT : sa_pkg::ST_OK;
				e_slot   = SW'(slot_q);
				e_evict  = full ? SW'(slot_q) : '0;
				e_gen    = gen_next;
				e_live   = 1'b1;
				e_count  = full ? total_q : total_q + CW'(1);
			end
			S_REL_EMIT: begin
				do_emit = out_free;
				e_gen   = gen_q;
			end
			S_QRY_EMIT: begin
				do_emit = out_free;
				e_gen   = slot_rd.gen;
				e_live  = slot_rd.live;
				e_pay   = slot_pay;
			end
			S_REJECT: begin
				do_emit  = out_free;
				e_status = sa_pkg::ST_REJECT;
			end
			S_EMPTY: begin
				do_emit  = out_free;
				e_status = sa_pkg::ST_EMPTY;
				e_slot   = '0;
			end
			S_LST_EMIT: begin
				do_emit = out_free;
				e_slot  = SW'(slot_q);
				e_gen   = slot_rd.gen;
				e_live  = slot_rd.live;
				e_pay   = slot_pay;
				e_last  = (remain_q == CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			idx_q          <= '0;
			pay_q          <= '0;
			next_q         <= '0;
			oldest_q       <= '0;
			lastpos_q      <= '0;
			walk_q         <= '0;
			slot_q         <= '0;
			total_q        <= '0;
			remain_q       <= '0;
			gen_q          <= '0;
			rsp_valid_q    <= 1'b0;
			status_q       <= sa_pkg::ST_OK;
			result_slot_q  <= '0;
			evicted_slot_q <= '0;
			gen_out_q      <= '0;
			live_out_q     <= 1'b0;
			pay_out_q      <= '0;
			count_out_q    <= '0;
			last_q         <= 1'b0;
		end else begin
			// hold a stalled beat, load a new one when the register frees
			rsp_valid_q <= do_emit || (rsp_valid_q && rsp_stall);
			if (do_emit) begin
				status_q       <= e_status;
				result_slot_q  <= e_slot;
				evicted_slot_q <= e_evict;
				gen_out_q      <= e_gen;
				live_out_q     <= e_live;
				pay_out_q      <= e_pay;
				count_out_q    <= e_count;
				last_q         <= e_last;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						idx_q <= slot_index;
						pay_q <= payload;
						unique case (req_mode)
							sa_pkg::MODE_ACQUIRE: state_q <= S_ACQ_SLOT;
							sa_pkg::MODE_RELEASE: begin
								if (idx_ok) begin
									lastpos_q <= ptr_y;
									state_q   <= S_REL_CHK;
								end else begin
									state_q <= S_REJECT;
								end
							end
							sa_pkg::MODE_QUERY: begin
								state_q <= idx_ok ? S_QRY_EMIT : S_REJECT;
							end
							sa_pkg::MODE_LIST: begin
								if (total_q == '0) begin
									state_q <= S_EMPTY;
								end else begin
									walk_q   <= ptr_y;
									remain_q <= total_q;
									state_q  <= S_LST_SLOT;
								end
							end
						endcase
					end
				end
				S_ACQ_SLOT: begin
					slot_q  <= ring_slot;
					state_q <= S_ACQ_EMIT;
				end
				S_ACQ_EMIT: begin
					if (out_free) begin
						next_q <= ptr_y;
						// when full the oldest pointer sits on the next pointer
						if (full) begin
							oldest_q <= ptr_y;
						end else begin
							total_q <= total_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_REL_CHK: begin
					if (!slot_rd.live) begin
						state_q <= S_REJECT;
					end else begin
						gen_q   <= slot_rd.gen;
						next_q  <= lastpos_q;
						total_q <= total_q - CW'(1);
						state_q <= S_REL_EMIT;
					end
				end
				S_REL_EMIT, S_QRY_EMIT, S_REJECT, S_EMPTY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LST_SLOT: begin
					slot_q  <= ring_slot;
					state_q <= S_LST_EMIT;
				end
				S_LST_EMIT: begin
					if (out_free) begin
						if (remain_q == CW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							walk_q   <= ptr_y;
							remain_q <= remain_q - CW'(1);
							state_q  <= S_LST_SLOT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign result_slot     = result_slot_q;
	assign evicted_slot    = evicted_slot_q;
	assign slot_generation = gen_out_q;
	assign slot_live       = live_out_q;
	assign slot_payload    = pay_out_q;
	assign live_count      = count_out_q;
	assign last            = last_q;

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CAP_C)
		else $error("live total above capacity");

	a_ptrs_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0 || total_q == CAP_C) |-> (oldest_q == next_q))
		else $error("ring pointers disagree with live total");

	a_evict_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == sa_pkg::ST_EVICT) |-> (evicted_slot_q == result_slot_q))
		else $error("evicted slot differs from reacquired slot");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LST_EMIT || state_q == S_LST_SLOT) |-> (remain_q != '0))
		else $error("list walk with nothing left");
`endif

endmodule

### sim/slot_allocator_fifo_eviction_test.sv
`timescale 1ns / 1ps
// Self-checking bench for slot_allocator_fifo_eviction: a slot pool model predicts every
// result beat, and fill, drain and mixed phases run, most with gaps on both sides.
// Depends on sa_pkg and the RTL top level only.

typedef struct packed {
	sa_pkg::status_t                status;
	logic [sa_pkg::SLOT_W-1:0]      slot;
	logic [sa_pkg::SLOT_W-1:0]      evicted;
	logic [sa_pkg::GEN_W-1:0]       gen;
	logic                           live;
	logic [sa_pkg::DEF_PAYLOAD_BITS-1:0] data;
	logic [sa_pkg::CNT_W-1:0]       count;
	logic                           last;
} slot_beat_t;

class slot_pool_model;
	localparam int CAP = sa_pkg::DEF_CAPACITY;

	logic [63:0] stored [CAP];
	bit          live [CAP];
	logic [31:0] gen [CAP];
	int          ring [CAP];
	int          pos_of [CAP];
	int          oldest;
	int          next_pos;
	int          live_n;
	slot_beat_t  due [$];
	int          mismatches;

	function new();
		for (int i = 0; i < CAP; i++) begin
			stored[i] = '0;
			live[i]   = 1'b0;
			gen[i]    = '0;
			ring[i]   = i;
			pos_of[i] = 0;
		end
		oldest     = 0;
		next_pos   = 0;
		live_n     = 0;
		mismatches = 0;
	endfunction

	function void push_beat(sa_pkg::status_t st, int slot, int victim, logic [31:0] g,
			bit lv, logic [63:0] d, bit fin);
		slot_beat_t b;
		b.status  = st;
		b.slot    = slot[5:0];
		b.evicted = victim[5:0];
		b.gen     = g;
		b.live    = lv;
		b.data    = d;
		b.count   = live_n[6:0];
		b.last    = fin;
		due.push_back(b);
	endfunction

	// Advance the pool by one accepted request and queue the beats it causes
	function void note_request(sa_pkg::mode_t m, logic [5:0] idx, logic [63:0] d);
		sa_pkg::status_t st;
		int victim;
		int slot;
		int p;
		int lp;
		int moved;
		case (m)
			sa_pkg::MODE_ACQUIRE: begin
				st     = sa_pkg::ST_OK;
				victim = 0;
				if (live_n >= CAP) begin
					victim = ring[oldest];
					gen[victim]++;
					live[victim] = 1'b0;
					oldest = (oldest + 1) % CAP;
					live_n--;
					st = sa_pkg::ST_EVICT;
				end
				slot = ring[next_pos];
				gen[slot]++;
				stored[slot] = d;
				live[slot]   = 1'b1;
				pos_of[slot] = next_pos;
				next_pos = (next_pos + 1) % CAP;
				live_n++;
				push_beat(st, slot, victim, gen[slot], 1'b1, '0, 1'b1);
			end
			sa_pkg::MODE_RELEASE: begin
				if (idx >= CAP || !live[idx]) begin
					push_beat(sa_pkg::ST_REJECT, idx, 0, '0, 1'b0, '0, 1'b1);
				end else begin
					p  = pos_of[idx];
					lp = (next_pos + CAP - 1) % CAP;
					// fill the hole with the newest live slot
					if (p != lp) begin
						moved = ring[lp];
						ring[p] = moved;
						pos_of[moved] = p;
					end
					ring[lp]  = idx;
					live[idx] = 1'b0;
					next_pos  = lp;
					live_n--;
					push_beat(sa_pkg::ST_OK, idx, 0, gen[idx], 1'b0, '0, 1'b1);
				end
			end
			sa_pkg::MODE_QUERY: begin
				if (idx >= CAP)
					push_beat(sa_pkg::ST_REJECT, idx, 0, '0, 1'b0, '0, 1'b1);
				else
					push_beat(sa_pkg::ST_OK, idx, 0, gen[idx], live[idx], stored[idx], 1'b1);
			end
			default: begin
				if (live_n == 0) begin
					push_beat(sa_pkg::ST_EMPTY, 0, 0, '0, 1'b0, '0, 1'b1);
				end else begin
					p = oldest;
					for (int i = 0; i < live_n; i++) begin
						slot = ring[p];
						push_beat(sa_pkg::ST_OK, slot, 0, gen[slot], live[slot], stored[slot],
							i == live_n - 1);
						p = (p + 1) % CAP;
					end
				end
			end
		endcase
	endfunction

	function string show(slot_beat_t b);
		return $sformatf("st=%0d slot=%0d ev=%0d gen=%h live=%0b data=%h cnt=%0d last=%0b",
			b.status, b.slot, b.evicted, b.gen, b.live, b.data, b.count, b.last);
	endfunction

	function void check_result(slot_beat_t got);
		slot_beat_t want;
		if (due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t unexpected beat: %s", $time, show(got));
		end else begin
			want = due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t beat mismatch", $time);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		end
	endfunction

	function int pending();
		return due.size();
	endfunction

	// A currently live slot, or any in-range slot when the pool is empty
	function int pick_live();
		if (live_n == 0)
			return $urandom_range(0, CAP - 1);
		return ring[(oldest + $urandom_range(0, live_n - 1)) % CAP];
	endfunction
endclass

module slot_allocator_fifo_eviction_test;
	localparam int CAPACITY = sa_pkg::DEF_CAPACITY;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 31;
	localparam int PH_MIXED = 0;
	localparam int PH_FILL  = 1;
	localparam int PH_DRAIN = 2;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  mode = sa_pkg::MODE_ACQUIRE;
	logic [5:0]  slot_index = '0;
	logic [63:0] payload = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  status;
	logic [5:0]  result_slot;
	logic [5:0]  evicted_slot;
	logic [31:0] slot_generation;
	logic        slot_live;
	logic [63:0] slot_payload;
	logic [6:0]  live_count;
	logic        last;

	slot_pool_model pool = new();
	bit          quiet = 1'b0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	slot_beat_t  seen;

	slot_allocator_fifo_eviction dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .slot_index(slot_index), .payload(payload),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .result_slot(result_slot), .evicted_slot(evicted_slot),
		.slot_generation(slot_generation), .slot_live(slot_live),
		.slot_payload(slot_payload), .live_count(live_count), .last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic issue(input sa_pkg::mode_t m, input logic [5:0] idx, input logic [63:0] d);
		int gap;
		gap = quiet ? 0 : gap_len();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid  <= 1'b1;
		mode       <= m;
		slot_index <= idx;
		payload    <= d;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pool.note_request(m, idx, d);
	endtask

	// Receiver back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen.status  = sa_pkg::status_t'(status);
			seen.slot    = result_slot;
			seen.evicted = evicted_slot;
			seen.gen     = slot_generation;
			seen.live    = slot_live;
			seen.data    = slot_payload;
			seen.count   = live_count;
			seen.last    = last;
			pool.check_result(seen);
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		int r;
		sa_pkg::mode_t m;
		logic [5:0] idx;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty pool, range edges, both release paths
		issue(sa_pkg::MODE_LIST, 6'd0, '0);
		issue(sa_pkg::MODE_QUERY, 6'd0, '0);
		issue(sa_pkg::MODE_QUERY, 6'd63, '1);
		issue(sa_pkg::MODE_QUERY, 6'd32, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd0, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd63, '0);
		issue(sa_pkg::MODE_ACQUIRE, 6'd63, 64'h0);
		issue(sa_pkg::MODE_ACQUIRE, 6'd0, '1);
		issue(sa_pkg::MODE_ACQUIRE, 6'd21, 64'haaaa_aaaa_aaaa_aaaa);
		issue(sa_pkg::MODE_ACQUIRE, 6'd42, 64'h5555_5555_5555_5555);
		issue(sa_pkg::MODE_QUERY, 6'd1, '0);
		issue(sa_pkg::MODE_QUERY, 6'd31, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd1, '0);
		issue(sa_pkg::MODE_QUERY, 6'd1, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd2, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd2, '0);
		issue(sa_pkg::MODE_LIST, 6'd63, '1);
		issue(sa_pkg::MODE_ACQUIRE, 6'd0, 64'h8000_0000_0000_0001);
		issue(sa_pkg::MODE_ACQUIRE, 6'd0, 64'h0123_4567_89ab_cdef);
		issue(sa_pkg::MODE_QUERY, 6'd62, '0);
		issue(sa_pkg::MODE_LIST, 6'd0, '0);
		issue(sa_pkg::MODE_RELEASE, 6'd0, '0);
		issue(sa_pkg::MODE_LIST, 6'd0, '0);

		// mixed phase, fill phases to force evictions, drain phases, then a mixed phase
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1, 2: kind = PH_FILL;
				3, 4: kind = PH_DRAIN;
				default: kind = PH_MIXED;
			endcase
			quiet = (ph % 3 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				case (kind)
					PH_FILL:  m = r < 70 ? sa_pkg::MODE_ACQUIRE : r < 80 ? sa_pkg::MODE_RELEASE :
						r < 92 ? sa_pkg::MODE_QUERY : sa_pkg::MODE_LIST;
					PH_DRAIN: m = r < 8 ? sa_pkg::MODE_ACQUIRE : r < 78 ? sa_pkg::MODE_RELEASE :
						r < 90 ? sa_pkg::MODE_QUERY : sa_pkg::MODE_LIST;
					default:  m = r < 40 ? sa_pkg::MODE_ACQUIRE : r < 65 ? sa_pkg::MODE_RELEASE :
						r < 88 ? sa_pkg::MODE_QUERY : sa_pkg::MODE_LIST;
				endcase
				r = $urandom_range(0, 99);
				if (m == sa_pkg::MODE_RELEASE)
					idx = r < 70 ? 6'(pool.pick_live()) : r < 90 ?
						6'($urandom_range(0, CAPACITY - 1)) : 6'($urandom_range(CAPACITY, 63));
				else if (m == sa_pkg::MODE_QUERY)
					idx = r < 50 ? 6'(pool.pick_live()) : r < 80 ?
						6'($urandom_range(0, CAPACITY - 1)) : 6'($urandom_range(0, 63));
				else
					idx = 6'($urandom_range(0, 63));
				issue(m, idx, rand_word());
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		req_valid <= 1'b0;
		while (pool.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pool.mismatches == 0 && pool.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### sim.f
rtl/sa_pkg.sv
rtl/sa_ptr_unit.sv
rtl/sa_ring.sv
rtl/sa_slots.sv
rtl/slot_allocator_fifo_eviction.sv
sim/slot_allocator_fifo_eviction_test.sv
